// ===== hdl/vt44_pkg.sv =====
package vt44_pkg;

  localparam int unsigned ElemW    = 32;
  localparam int unsigned ProdW    = 2 * ElemW;
  localparam int unsigned SumW     = ProdW + 2;
  localparam int unsigned NumRegs  = 8;
  localparam int unsigned RegIdxW  = 3;
  localparam int unsigned ApbDataW = 64;
  localparam int unsigned ApbAddrW = RegIdxW + 3;

  // register index, byte address is 8 * index
  typedef enum logic [RegIdxW-1:0] {
    REG_ROW0_C01 = 3'd0,
    REG_ROW0_C23 = 3'd1,
    REG_ROW1_C01 = 3'd2,
    REG_ROW1_C23 = 3'd3,
    REG_ROW2_C01 = 3'd4,
    REG_ROW2_C23 = 3'd5,
    REG_ROW3_C01 = 3'd6,
    REG_ROW3_C23 = 3'd7
  } vt44_reg_e;

  typedef logic [NumRegs-1:0][ApbDataW-1:0] vt44_regs_t;

  // one matrix column, element of row r at index r
  typedef logic [3:0][ElemW-1:0] vt44_col_t;

  typedef struct packed {
    logic                    command;
    logic signed [ElemW-1:0] in_x;
    logic signed [ElemW-1:0] in_y;
    logic signed [ElemW-1:0] in_z;
  } vt44_in_t;

  typedef struct packed {
    logic signed [ElemW-1:0] out_x;
    logic signed [ElemW-1:0] out_y;
    logic signed [ElemW-1:0] out_z;
    logic                    saturated;
  } vt44_out_t;

  // stage load enables
  typedef struct packed {
    logic s1;
    logic s2;
    logic s3;
  } vt44_stg_t;

endpackage

// ===== hdl/vt44_cfg_regs.sv =====
module vt44_cfg_regs #(
  parameter int unsigned FRAC_BITS = 16
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            psel,
  input  logic                            penable,
  input  logic                            pwrite,
  input  logic [vt44_pkg::ApbAddrW-1:0]   paddr,
  input  logic [vt44_pkg::ApbDataW-1:0]   pwdata,
  output logic [vt44_pkg::ApbDataW-1:0]   prdata,
  output logic                            pready,
  output vt44_pkg::vt44_regs_t            regs_o
);
  import vt44_pkg::*;

  localparam logic [ApbDataW-1:0] OneLo = ApbDataW'(1) << FRAC_BITS;
  localparam logic [ApbDataW-1:0] OneHi = ApbDataW'(1) << (FRAC_BITS + ElemW);
  localparam logic [ApbDataW-1:0] Zero  = '0;

  // identity matrix, register 7 down to register 0
  localparam vt44_regs_t RegsRst = {OneHi, Zero, OneLo, Zero, Zero, OneHi, Zero, OneLo};

  vt44_regs_t regs_q;
  vt44_reg_e  idx;
  logic       wr_en;

  assign idx    = vt44_reg_e'(paddr[ApbAddrW-1:3]);
  assign wr_en  = psel & penable & pwrite;
  assign pready = 1'b1;
  assign prdata = regs_q[idx];
  assign regs_o = regs_q;

  // identity matrix at reset
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      regs_q <= RegsRst;
    end else if (wr_en) begin
      unique case (idx)
        REG_ROW0_C01: regs_q[REG_ROW0_C01] <= pwdata;
        REG_ROW0_C23: regs_q[REG_ROW0_C23] <= pwdata;
        REG_ROW1_C01: regs_q[REG_ROW1_C01] <= pwdata;
        REG_ROW1_C23: regs_q[REG_ROW1_C23] <= pwdata;
        REG_ROW2_C01: regs_q[REG_ROW2_C01] <= pwdata;
        REG_ROW2_C23: regs_q[REG_ROW2_C23] <= pwdata;
        REG_ROW3_C01: regs_q[REG_ROW3_C01] <= pwdata;
        REG_ROW3_C23: regs_q[REG_ROW3_C23] <= pwdata;
        default:      regs_q               <= regs_q;
      endcase
    end
  end

endmodule

// ===== hdl/vt44_lane.sv =====
module vt44_lane #(
  parameter int unsigned FRAC_BITS = 16
) (
  input  logic                                clk_i,
  input  vt44_pkg::vt44_stg_t                 stg_i,
  input  vt44_pkg::vt44_in_t                  item_i,
  input  vt44_pkg::vt44_col_t                 col_i,
  output logic signed [vt44_pkg::ElemW-1:0]   value_o,
  output logic                                sat_o
);
  import vt44_pkg::*;

  localparam int unsigned HiW = SumW - ElemW - FRAC_BITS + 1;

  logic signed [ProdW-1:0] p0_d, p1_d, p2_d, p3_d;
  logic signed [ProdW-1:0] p0_q, p1_q, p2_q, p3_q;
  logic signed [SumW-1:0]  sum_d, sum_q, rnd;
  logic [HiW-1:0]          hi;
  logic signed [ElemW-1:0] value_d, value_q;
  logic                    sat_d, sat_q;

  // stage 1: three products and the translation term
  always_comb begin
    p0_d = item_i.in_x * $signed(col_i[0]);
    p1_d = item_i.in_y * $signed(col_i[1]);
    p2_d = item_i.in_z * $signed(col_i[2]);
    if (item_i.command) begin
      p3_d = '0;
    end else begin
      p3_d = {{(ProdW-ElemW-FRAC_BITS){col_i[3][ElemW-1]}}, col_i[3], {FRAC_BITS{1'b0}}};
    end
  end

  // stage 2: exact sum
  assign sum_d = SumW'(p0_q) + SumW'(p1_q) + SumW'(p2_q) + SumW'(p3_q);

  // stage 3: round half up, saturate
  always_comb begin
    rnd = sum_q + (SumW'(1) <<< (FRAC_BITS - 1));
    hi  = rnd[SumW-1:ElemW+FRAC_BITS-1];
    if ((hi == '0) || (hi == '1)) begin
      value_d = rnd[ElemW+FRAC_BITS-1:FRAC_BITS];
      sat_d   = 1'b0;
    end else begin
      value_d = rnd[SumW-1] ? {1'b1, {(ElemW-1){1'b0}}} : {1'b0, {(ElemW-1){1'b1}}};
      sat_d   = 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (stg_i.s1) begin
      p0_q <= p0_d;
      p1_q <= p1_d;
      p2_q <= p2_d;
      p3_q <= p3_d;
    end
    if (stg_i.s2) begin
      sum_q <= sum_d;
    end
    if (stg_i.s3) begin
      value_q <= value_d;
      sat_q   <= sat_d;
    end
  end

  assign value_o = value_q;
  assign sat_o   = sat_q;

endmodule

// ===== hdl/vertex_transform_4x4.sv =====
// vertex_transform_4x4: transforms one vertex per item through a 4x4 matrix
// (row-vector convention, fixed point with FRAC_BITS fraction bits)
// input channel: start with item_i; an item is taken at an edge where
//   start is high and busy is low; busy stays low, so an item can
//   enter in every cycle
// result channel: done_o is high for one cycle with result_o; the receiver
//   takes it at the edge that ends that cycle and cannot stall it
// pipeline: the accept edge loads stage 1, then stage 2 and stage 3 load in
//   turn; done_o is high while stage 3 holds a valid result
//   stage 1 multiplies (nine 32x32 multipliers), stage 2 sums the four
//   terms exactly, stage 3 rounds half up and saturates to 32 bits
// throughput: one item per cycle, no stage ever stalls
// config: apb port, 64-bit data, register i at byte address 8*i, pready
//   always high; write the matrix only while no item is in flight
// reset: the matrix returns to identity and the pipeline valid bits clear,
//   so no result appears until a new item is taken
module vertex_transform_4x4 #(
  parameter int unsigned FRAC_BITS = 16
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  // apb configuration port
  input  logic                            psel,
  input  logic                            penable,
  input  logic                            pwrite,
  input  logic [vt44_pkg::ApbAddrW-1:0]   paddr,
  input  logic [vt44_pkg::ApbDataW-1:0]   pwdata,
  output logic [vt44_pkg::ApbDataW-1:0]   prdata,
  output logic                            pready,
  // item in
  input  logic                            start,
  input  vt44_pkg::vt44_in_t              item_i,
  output logic                            busy,
  // result out
  output logic                            done_o,
  output vt44_pkg::vt44_out_t             result_o
);
  import vt44_pkg::*;

  vt44_regs_t              regs;
  vt44_col_t [2:0]         cols;
  logic signed [ElemW-1:0] lane_val [3];
  logic [2:0]              lane_sat;
  vt44_stg_t               stg;
  logic                    v1_q, v2_q, v3_q;

  // the pipeline never holds items off
  assign busy = 1'b0;

  vt44_cfg_regs #(
    .FRAC_BITS (FRAC_BITS)
  ) u_cfg (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .regs_o  (regs)
  );

  // valid bits travel with the data, one per stage
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
      v3_q <= 1'b0;
    end else begin
      v1_q <= start & ~busy;
      v2_q <= v1_q;
      v3_q <= v2_q;
    end
  end

  // each stage loads only when an item moves into it
  assign stg.s1 = start & ~busy;
  assign stg.s2 = v1_q;
  assign stg.s3 = v2_q;

  // element m[r][c] sits in register 2*r + c/2, low half for even c
  for (genvar c = 0; c < 3; c++) begin : g_lane
    for (genvar r = 0; r < 4; r++) begin : g_row
      assign cols[c][r] = regs[2*r + c/2][(c%2)*ElemW +: ElemW];
    end

    vt44_lane #(
      .FRAC_BITS (FRAC_BITS)
    ) u_lane (
      .clk_i   (clk_i),
      .stg_i   (stg),
      .item_i  (item_i),
      .col_i   (cols[c]),
      .value_o (lane_val[c]),
      .sat_o   (lane_sat[c])
    );
  end

  // lane 3 of the homogeneous product is not computed
  assign done_o             = v3_q;
  assign result_o.out_x     = lane_val[0];
  assign result_o.out_y     = lane_val[1];
  assign result_o.out_z     = lane_val[2];
  assign result_o.saturated = |lane_sat;

endmodule

// ===== sim/tb_top.sv =====
module tb_top;
  import vt44_pkg::*;

  localparam int unsigned FRAC        = 16;
  localparam int unsigned WIDE_W      = 70;
  localparam int unsigned PIPE_LAT    = 3;
  localparam int unsigned CYCLE_LIMIT = 200000;

  // command codes of an item
  localparam logic CMD_POINT     = 1'b0;
  localparam logic CMD_DIRECTION = 1'b1;

  localparam logic signed [ElemW-1:0]  ONE_Q    = 32'sh0001_0000;
  localparam logic signed [WIDE_W-1:0] HALF_LSB = 70'sd32768;
  localparam logic signed [WIDE_W-1:0] LANE_MAX = 70'sd2147483647;
  localparam logic signed [WIDE_W-1:0] LANE_MIN = -70'sd2147483648;

  typedef enum int {
    MAT_IDENTITY,
    MAT_ZERO,
    MAT_ALL_MAX,
    MAT_ALL_MIN,
    MAT_SMALL_RANDOM,
    MAT_FULL_RANDOM
  } matrix_kind_e;

  logic                clk_i;
  logic                rst_ni;
  logic                psel;
  logic                penable;
  logic                pwrite;
  logic [ApbAddrW-1:0] paddr;
  logic [ApbDataW-1:0] pwdata;
  logic [ApbDataW-1:0] prdata;
  logic                pready;
  logic                start;
  vt44_in_t            item_i;
  logic                busy;
  logic                done_o;
  vt44_out_t           result_o;

  // shadow copy of the matrix registers
  logic [ApbDataW-1:0] mat_regs [NumRegs];
  vt44_out_t           pending_transforms [$];
  int unsigned         mismatch_count;
  int unsigned         cycle_count;
  bit                  gaps_on;

  vertex_transform_4x4 #(
    .FRAC_BITS(FRAC)
  ) DUT (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .start   (start),
    .item_i  (item_i),
    .busy    (busy),
    .done_o  (done_o),
    .result_o(result_o)
  );

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  // element m[r][c]: even columns in the low half of a register, odd in the high half
  function automatic logic signed [ElemW-1:0] mat_elem(int r, int c);
    logic [ApbDataW-1:0] word;
    word = mat_regs[r * 2 + c / 2];
    return (c % 2) ? word[63:32] : word[31:0];
  endfunction

  function automatic logic signed [WIDE_W-1:0] wide_mul(logic signed [ElemW-1:0] a,
                                                        logic signed [ElemW-1:0] b);
    logic signed [WIDE_W-1:0] ea;
    logic signed [WIDE_W-1:0] eb;
    ea = a;
    eb = b;
    return ea * eb;
  endfunction

  // row vector times matrix, exact sum, round half up, clamp each lane
  function automatic vt44_out_t transform_vertex(vt44_in_t v);
    logic signed [WIDE_W-1:0] acc;
    logic signed [WIDE_W-1:0] rounded;
    logic signed [ElemW-1:0]  lane [3];
    logic                     clamped;
    vt44_out_t                res;
    clamped = 1'b0;
    for (int j = 0; j < 3; j++) begin
      acc = wide_mul(v.in_x, mat_elem(0, j)) + wide_mul(v.in_y, mat_elem(1, j))
          + wide_mul(v.in_z, mat_elem(2, j));
      if (v.command == CMD_POINT) acc = acc + wide_mul(ONE_Q, mat_elem(3, j));
      rounded = (acc + HALF_LSB) >>> FRAC;
      if (rounded > LANE_MAX) begin
        lane[j] = 32'h7FFF_FFFF;
        clamped = 1'b1;
      end else if (rounded < LANE_MIN) begin
        lane[j] = 32'h8000_0000;
        clamped = 1'b1;
      end else begin
        lane[j] = rounded[31:0];
      end
    end
    res.out_x     = lane[0];
    res.out_y     = lane[1];
    res.out_z     = lane[2];
    res.saturated = clamped;
    return res;
  endfunction

  task automatic report_mismatch(string what, logic [63:0] got, logic [63:0] want);
    $display("cycle %0d: %s got %h expected %h", cycle_count, what, got, want);
    mismatch_count++;
  endtask

  // apb write: setup cycle, then access cycle until pready
  task automatic write_matrix_reg(vt44_reg_e idx, logic [ApbDataW-1:0] value);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 3'b000};
    pwdata  <= value;
    @(posedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    mat_regs[idx] = value;
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    @(posedge clk_i);
  endtask

  task automatic read_matrix_reg(vt44_reg_e idx);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    paddr   <= {idx, 3'b000};
    @(posedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    if (prdata !== mat_regs[idx]) report_mismatch($sformatf("readback %s", idx.name()),
                                                  prdata, mat_regs[idx]);
    psel    <= 1'b0;
    penable <= 1'b0;
    @(posedge clk_i);
  endtask

  function automatic logic [ElemW-1:0] small_elem();
    // roughly -4.0 .. +4.0
    return $urandom_range(0, 32'h7_FFFF) - 32'h4_0000;
  endfunction

  task automatic program_matrix(matrix_kind_e kind);
    logic [ApbDataW-1:0] word;
    for (int i = 0; i < NumRegs; i++) begin
      case (kind)
        MAT_IDENTITY: begin
          // diagonal sits low in rows 0 and 2 (registers 0 and 5), high in rows 1 and 3 (registers 2 and 7)
          case (vt44_reg_e'(i))
            REG_ROW0_C01, REG_ROW2_C23: word = 64'h0000_0000_0001_0000;
            REG_ROW1_C01, REG_ROW3_C23: word = 64'h0001_0000_0000_0000;
            default:                    word = '0;
          endcase
        end
        MAT_ZERO:         word = '0;
        MAT_ALL_MAX:      word = {2{32'h7FFF_FFFF}};
        MAT_ALL_MIN:      word = {2{32'h8000_0000}};
        MAT_SMALL_RANDOM: word = {small_elem(), small_elem()};
        default:          word = {$urandom, $urandom};
      endcase
      write_matrix_reg(vt44_reg_e'(i), word);
    end
  endtask

  // sends one vertex, with an occasional gap before it when gaps_on is set
  task automatic send_vertex(logic cmd, logic [ElemW-1:0] x, logic [ElemW-1:0] y,
                             logic [ElemW-1:0] z);
    vt44_in_t v;
    v.command = cmd;
    v.in_x    = x;
    v.in_y    = y;
    v.in_z    = z;
    if (gaps_on && $urandom_range(0, 99) < 6) begin
      start <= 1'b0;
      repeat ($urandom_range(1, 3)) @(posedge clk_i);
    end
    start  <= 1'b1;
    item_i <= v;
    do @(posedge clk_i); while (busy);
    pending_transforms.push_back(transform_vertex(v));
  endtask

  // hold off until every expected result is back, then let the pipe settle
  task automatic drain_pipeline();
    start <= 1'b0;
    while (pending_transforms.size() != 0) @(posedge clk_i);
    repeat (PIPE_LAT + 1) @(posedge clk_i);
  endtask

  function automatic logic [ElemW-1:0] rand_coord();
    case ($urandom_range(0, 3))
      0: return $urandom;
      1: return $urandom_range(0, 32'h1F_FFFF) - 32'h10_0000;
      2: begin
        case ($urandom_range(0, 4))
          0:       return 32'h7FFF_FFFF;
          1:       return 32'h8000_0000;
          2:       return 32'h0000_0001;
          3:       return 32'hFFFF_FFFF;
          default: return 32'h0000_0000;
        endcase
      end
      default: return $urandom_range(0, 32'h07FF_FFFF) - 32'h0400_0000;
    endcase
  endfunction

  // reset matrix is the identity: coordinates pass through unchanged
  task automatic test_identity_at_reset();
    send_vertex(CMD_POINT,     32'h0000_0000, 32'h0000_0000, 32'h0000_0000);
    send_vertex(CMD_POINT,     32'h7FFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF);
    send_vertex(CMD_DIRECTION, 32'h8000_0000, 32'h7FFF_FFFF, 32'h8000_0000);
    send_vertex(CMD_POINT,     32'hFFFF_FFFF, 32'h0000_0001, 32'h0001_0000);
    send_vertex(CMD_DIRECTION, 32'hAAAA_AAAA, 32'h5555_5555, 32'hFFFF_FFFF);
    send_vertex(CMD_POINT,     32'h5555_5555, 32'hAAAA_AAAA, 32'h0000_0000);
    drain_pipeline();
  endtask

  task automatic test_register_access();
    for (int i = 0; i < NumRegs; i++) write_matrix_reg(vt44_reg_e'(i), '1);
    for (int i = 0; i < NumRegs; i++) read_matrix_reg(vt44_reg_e'(i));
    for (int i = 0; i < NumRegs; i++) write_matrix_reg(vt44_reg_e'(i), {$urandom, $urandom});
    for (int i = 0; i < NumRegs; i++) read_matrix_reg(vt44_reg_e'(i));
  endtask

  task automatic test_saturation_and_rounding();
    program_matrix(MAT_IDENTITY);
    // translation at the top of the range: one more lsb overflows
    write_matrix_reg(REG_ROW3_C01, {32'h0000_0000, 32'h7FFF_FFFF});
    send_vertex(CMD_POINT,     32'h0000_0000, 32'h0000_0000, 32'h0000_0000);
    send_vertex(CMD_POINT,     32'h0000_0001, 32'h0000_0000, 32'h0000_0000);
    send_vertex(CMD_DIRECTION, 32'h0000_0001, 32'h0000_0000, 32'h0000_0000);
    drain_pipeline();
    // translation at the bottom of the range
    write_matrix_reg(REG_ROW3_C01, {32'h8000_0000, 32'h8000_0000});
    send_vertex(CMD_POINT,     32'h0000_0000, 32'h0000_0000, 32'h0000_0000);
    send_vertex(CMD_POINT,     32'hFFFF_FFFF, 32'h0000_0001, 32'h0000_0000);
    send_vertex(CMD_POINT,     32'h0000_0000, 32'hFFFF_FFFF, 32'h0000_0000);
    drain_pipeline();
    // m[0][0] = 0.5 exercises the half-up rounding on both signs
    write_matrix_reg(REG_ROW3_C01, '0);
    write_matrix_reg(REG_ROW0_C01, {32'h0000_0000, 32'h0000_8000});
    send_vertex(CMD_POINT,     32'h0000_0001, 32'h0000_0000, 32'h0000_0000);
    send_vertex(CMD_POINT,     32'hFFFF_FFFF, 32'h0000_0000, 32'h0000_0000);
    send_vertex(CMD_DIRECTION, 32'h0000_0003, 32'h0000_0000, 32'h0000_0000);
    send_vertex(CMD_DIRECTION, 32'hFFFF_FFFD, 32'h0000_0000, 32'h0000_0000);
    drain_pipeline();
    // every lane clamps high, then every lane clamps low
    program_matrix(MAT_ALL_MAX);
    send_vertex(CMD_POINT,     32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF);
    send_vertex(CMD_DIRECTION, 32'h8000_0000, 32'h8000_0000, 32'h8000_0000);
    drain_pipeline();
  endtask

  task automatic run_phase(matrix_kind_e kind, int unsigned n_items, bit with_gaps,
                           bit hold_midway);
    program_matrix(kind);
    gaps_on = with_gaps;
    for (int unsigned n = 0; n < n_items; n++) begin
      if (hold_midway && n == n_items / 2) drain_pipeline();
      send_vertex($urandom_range(0, 1) ? CMD_DIRECTION : CMD_POINT,
                  rand_coord(), rand_coord(), rand_coord());
    end
    drain_pipeline();
  endtask

  task automatic test_random_transforms();
    run_phase(MAT_IDENTITY,     200, 1'b1, 1'b0);
    run_phase(MAT_SMALL_RANDOM, 250, 1'b1, 1'b1);
    // long run with back-to-back items
    run_phase(MAT_FULL_RANDOM,  300, 1'b0, 1'b0);
    run_phase(MAT_ALL_MAX,      150, 1'b1, 1'b0);
    run_phase(MAT_ALL_MIN,      150, 1'b1, 1'b0);
    run_phase(MAT_ZERO,         100, 1'b1, 1'b0);
    run_phase(MAT_SMALL_RANDOM, 250, 1'b1, 1'b0);
    run_phase(MAT_FULL_RANDOM,  200, 1'b1, 1'b0);
  endtask

  // each result must match the oldest pending transform
  always @(posedge clk_i) begin : result_check
    vt44_out_t want;
    if (rst_ni && done_o) begin
      if (pending_transforms.size() == 0) begin
        report_mismatch("result with nothing pending", 64'(result_o.out_x), '0);
      end else begin
        want = pending_transforms.pop_front();
        if (result_o.out_x !== want.out_x)
          report_mismatch("out_x", 64'(result_o.out_x), 64'(want.out_x));
        if (result_o.out_y !== want.out_y)
          report_mismatch("out_y", 64'(result_o.out_y), 64'(want.out_y));
        if (result_o.out_z !== want.out_z)
          report_mismatch("out_z", 64'(result_o.out_z), 64'(want.out_z));
        if (result_o.saturated !== want.saturated)
          report_mismatch("saturated", 64'(result_o.saturated), 64'(want.saturated));
      end
    end
  end

  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("timeout, %0d transforms still pending", pending_transforms.size());
      $display("SCOREBOARD MISMATCH");
      $finish;
    end
  end

  initial begin
    mismatch_count = 0;
    cycle_count    = 0;
    gaps_on        = 1'b1;
    rst_ni  <= 1'b0;
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    paddr   <= '0;
    pwdata  <= '0;
    start   <= 1'b0;
    item_i  <= '0;
    // identity matrix after reset
    for (int i = 0; i < NumRegs; i++) mat_regs[i] = '0;
    mat_regs[REG_ROW0_C01] = 64'h0000_0000_0001_0000;
    mat_regs[REG_ROW1_C01] = 64'h0001_0000_0000_0000;
    mat_regs[REG_ROW2_C23] = 64'h0000_0000_0001_0000;
    mat_regs[REG_ROW3_C23] = 64'h0001_0000_0000_0000;
    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_identity_at_reset();
    test_register_access();
    test_saturation_and_rounding();
    test_random_transforms();

    while (pending_transforms.size() != 0) @(posedge clk_i);
    repeat (PIPE_LAT + 5) @(posedge clk_i);
    if (mismatch_count == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule
